/* sv/mmp_pkg.sv */
// shared types, constants and helpers for the matrix multiply and power block
`timescale 1ns / 1ps
package mmp_pkg;

    localparam int MAX_DIM    = 8;
    localparam int DATA_WIDTH = 32;
    localparam int CELLS      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIM_W      = 4;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = PROD_W + IDX_W + 1;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_A_ROWS   = 3'd1,
        CFG_A_COLS   = 3'd2,
        CFG_B_COLS   = 3'd3,
        CFG_EXPONENT = 3'd4
    } cfg_index_t;

    // matrix store selection
    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_W = 2'd2,
        SEL_S = 2'd3
    } mat_sel_t;

    typedef struct packed {
        logic                          cmd;
        logic signed [DATA_WIDTH-1:0]  element;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0]  product_element;
        logic                          last;
    } out_item_t;

    // tag travelling down the multiply-accumulate pipeline
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] dst_addr;
        mat_sel_t          dst_sel;
    } mac_tag_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_a;
        logic              load_b;
        logic [ADDR_W-1:0] load_addr;
        mac_tag_t          tag;
        logic [ADDR_W-1:0] l_addr;
        mat_sel_t          l_sel;
        logic [ADDR_W-1:0] r_addr;
        mat_sel_t          r_sel;
        logic              out_load;
        logic              out_last;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // zero acts as one, above the maximum acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage

/* sv/mmp_datapath.sv */
// matrix stores, multiply-accumulate pipeline and output register
`timescale 1ns / 1ps
module mmp_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mmp_pkg::dp_cmd_t                     cmd,
    input  logic signed [mmp_pkg::DATA_WIDTH-1:0] element,
    output mmp_pkg::dp_status_t                  status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output mmp_pkg::out_item_t                   out_item
);
    import mmp_pkg::*;

    logic [DATA_WIDTH-1:0] a_mem [CELLS];
    logic [DATA_WIDTH-1:0] b_mem [CELLS];
    logic [DATA_WIDTH-1:0] w_mem [CELLS];
    logic [DATA_WIDTH-1:0] s_mem [CELLS];

    logic [DATA_WIDTH-1:0] a_l_rd_reg, a_r_rd_reg, b_rd_reg, w_rd_reg, s_rd_reg;
    mat_sel_t              l_sel_reg, r_sel_reg;
    mac_tag_t              tag1_reg, tag2_reg, tag3_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [DATA_WIDTH-1:0] left_op, right_op;
    logic [DATA_WIDTH-1:0] sat_val;
    logic                  wr_w, wr_s;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    // input stores, two read ports on a since power mode reads it twice
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
            a_mem[cmd.load_addr] <= element;
        a_l_rd_reg <= a_mem[cmd.l_addr];
        a_r_rd_reg <= a_mem[cmd.r_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b)
            b_mem[cmd.load_addr] <= element;
        b_rd_reg <= b_mem[cmd.r_addr];
    end

    // ping-pong result stores
    always_ff @(posedge clk)
    begin
        if (wr_w)
            w_mem[tag3_reg.dst_addr] <= sat_val;
        w_rd_reg <= w_mem[cmd.l_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_s)
            s_mem[tag3_reg.dst_addr] <= sat_val;
        s_rd_reg <= s_mem[cmd.l_addr];
    end

    // operand selection behind the read registers
    always_comb
    begin
        case (l_sel_reg)
            SEL_W:   left_op = signed'(w_rd_reg);
            SEL_S:   left_op = signed'(s_rd_reg);
            default: left_op = signed'(a_l_rd_reg);
        endcase
        case (r_sel_reg)
            SEL_B:   right_op = signed'(b_rd_reg);
            default: right_op = signed'(a_r_rd_reg);
        endcase
    end

    // pipeline tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag1_reg <= cmd.tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    // multiply, then accumulate with the rounding bias on the first term
    always_comb
    begin
        acc_next = (tag2_reg.first ? ACC_W'(1 << (FRAC_W - 1)) : acc_reg)
                 + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk)
    begin
        l_sel_reg <= cmd.l_sel;
        r_sel_reg <= cmd.r_sel;
        prod_reg  <= left_op * right_op;
        if (tag2_reg.valid)
            acc_reg <= acc_next;
    end

    // saturate to the element width
    always_comb
    begin
        if ((&acc_reg[ACC_W-1:FRAC_W+DATA_WIDTH-1]) || ~(|acc_reg[ACC_W-1:FRAC_W+DATA_WIDTH-1]))
            sat_val = acc_reg[FRAC_W+DATA_WIDTH-1:FRAC_W];
        else if (acc_reg[ACC_W-1])
            sat_val = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            sat_val = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end

    assign wr_w = tag3_reg.valid && tag3_reg.last && (tag3_reg.dst_sel == SEL_W);
    assign wr_s = tag3_reg.valid && tag3_reg.last && (tag3_reg.dst_sel == SEL_S);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_item_reg.product_element <= left_op;
            out_item_reg.last            <= cmd.out_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_item        = out_item_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // checks
    a_load_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_a && cmd.load_b))
        else $error("a and b loaded in the same cycle");
    no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");
    last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tag3_reg.last |-> tag3_reg.valid)
        else $error("stray last tag in pipeline");

endmodule

/* sv/mmp_ctrl.sv */
// configuration registers, load counters and sequencing state machine
`timescale 1ns / 1ps
module mmp_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_cmd,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmp_pkg::CFG_DATA_W-1:0] cfg_data,
    output mmp_pkg::dp_cmd_t               cmd,
    input  mmp_pkg::dp_status_t            status
);
    import mmp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MAC    = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_OUT_RD = 5'b01000,
        ST_OUT_LD = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic                mode_reg;
    logic [DIM_W-1:0]    a_rows_reg, a_cols_reg, b_cols_reg;
    logic [7:0]          exponent_reg;
    logic [CNT_W-1:0]    a_cnt_reg, a_cnt_next, b_cnt_reg, b_cnt_next;
    logic [IDX_W-1:0]    i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [7:0]          pass_reg, pass_next;
    mat_sel_t            left_sel_reg, left_sel_next, right_sel_reg, right_sel_next;
    mat_sel_t            dst_sel_reg, dst_sel_next, res_sel_reg, res_sel_next;
    logic [1:0]          drain_reg, drain_next;
    logic [ADDR_W-1:0]   out_idx_reg, out_idx_next;

    logic [DIM_W-1:0]    rows, inner, cols;
    logic [CNT_W-1:0]    a_total, b_total, n_total;
    logic                accept, store_a, store_b, complete;
    logic                k_end, j_end, i_end, out_end;

    // effective dimensions
    always_comb
    begin
        rows    = clamp_dim(a_rows_reg);
        inner   = mode_reg ? rows : clamp_dim(a_cols_reg);
        cols    = mode_reg ? rows : clamp_dim(b_cols_reg);
        a_total = CNT_W'(rows) * CNT_W'(inner);
        b_total = mode_reg ? '0 : CNT_W'(inner) * CNT_W'(cols);
        n_total = CNT_W'(rows) * CNT_W'(cols);
    end

    // configuration writes, taken only between computations
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            a_rows_reg   <= DIM_W'(MAX_DIM);
            a_cols_reg   <= DIM_W'(MAX_DIM);
            b_cols_reg   <= DIM_W'(MAX_DIM);
            exponent_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg     <= cfg_data[0];
                CFG_A_ROWS:   a_rows_reg   <= cfg_data[DIM_W-1:0];
                CFG_A_COLS:   a_cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_B_COLS:   b_cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_EXPONENT: exponent_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // load bookkeeping
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign store_a    = accept && !in_cmd && (a_cnt_reg < a_total);
    assign store_b    = accept && in_cmd && !mode_reg && (b_cnt_reg < b_total);
    assign a_cnt_next = a_cnt_reg + CNT_W'(store_a);
    assign b_cnt_next = b_cnt_reg + CNT_W'(store_b);
    assign complete   = accept && (a_cnt_next >= a_total) && (b_cnt_next >= b_total);

    assign k_end   = ({1'b0, k_reg} == inner - DIM_W'(1));
    assign j_end   = ({1'b0, j_reg} == cols - DIM_W'(1));
    assign i_end   = ({1'b0, i_reg} == rows - DIM_W'(1));
    assign out_end = (CNT_W'(out_idx_reg) == n_total - CNT_W'(1));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        left_sel_next  = left_sel_reg;
        right_sel_next = right_sel_reg;
        dst_sel_next   = dst_sel_reg;
        res_sel_next   = res_sel_reg;
        drain_next     = drain_reg;
        out_idx_next   = out_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (complete)
                begin
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    out_idx_next = '0;
                    if (mode_reg && (exponent_reg < 8'd2))
                    begin
                        res_sel_next = SEL_A;
                        state_next   = ST_OUT_RD;
                    end
                    else
                    begin
                        left_sel_next  = SEL_A;
                        right_sel_next = mode_reg ? SEL_A : SEL_B;
                        dst_sel_next   = mode_reg ? SEL_W : SEL_S;
                        pass_next      = mode_reg ? exponent_reg - 8'd1 : 8'd1;
                        state_next     = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                k_next = k_reg + IDX_W'(1);
                if (k_end)
                begin
                    k_next = '0;
                    j_next = j_reg + IDX_W'(1);
                    if (j_end)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                        if (i_end)
                        begin
                            i_next     = '0;
                            drain_next = 2'd3;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd0)
                begin
                    pass_next = pass_reg - 8'd1;
                    if (pass_reg == 8'd1)
                    begin
                        res_sel_next = dst_sel_reg;
                        state_next   = ST_OUT_RD;
                    end
                    else
                    begin
                        left_sel_next = dst_sel_reg;
                        dst_sel_next  = (dst_sel_reg == SEL_W) ? SEL_S : SEL_W;
                        state_next    = ST_MAC;
                    end
                end
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                if (status.out_free)
                begin
                    if (out_end)
                        state_next = ST_IDLE;
                    else
                    begin
                        out_idx_next = out_idx_reg + ADDR_W'(1);
                        state_next   = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            left_sel_reg  <= SEL_A;
            right_sel_reg <= SEL_A;
            dst_sel_reg   <= SEL_W;
            res_sel_reg   <= SEL_A;
            drain_reg     <= '0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            a_cnt_reg     <= complete ? '0 : a_cnt_next;
            b_cnt_reg     <= complete ? '0 : b_cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            left_sel_reg  <= left_sel_next;
            right_sel_reg <= right_sel_next;
            dst_sel_reg   <= dst_sel_next;
            res_sel_reg   <= res_sel_next;
            drain_reg     <= drain_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd              = '0;
        cmd.load_a       = store_a;
        cmd.load_b       = store_b;
        cmd.load_addr    = store_a ? a_cnt_reg[ADDR_W-1:0] : b_cnt_reg[ADDR_W-1:0];
        cmd.tag.valid    = (state_reg == ST_MAC);
        cmd.tag.first    = (k_reg == '0);
        cmd.tag.last     = k_end && (state_reg == ST_MAC);
        cmd.tag.dst_addr = ADDR_W'(CNT_W'(i_reg) * CNT_W'(cols) + CNT_W'(j_reg));
        cmd.tag.dst_sel  = dst_sel_reg;
        cmd.r_addr       = ADDR_W'(CNT_W'(k_reg) * CNT_W'(cols) + CNT_W'(j_reg));
        cmd.r_sel        = right_sel_reg;
        if (state_reg == ST_MAC)
        begin
            cmd.l_addr = ADDR_W'(CNT_W'(i_reg) * CNT_W'(inner) + CNT_W'(k_reg));
            cmd.l_sel  = left_sel_reg;
        end
        else
        begin
            cmd.l_addr = out_idx_reg;
            cmd.l_sel  = res_sel_reg;
        end
        cmd.out_load = (state_reg == ST_OUT_LD) && status.out_free;
        cmd.out_last = out_end;
    end

    // checks
    counts_idle_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (a_cnt_reg == '0 && b_cnt_reg == '0))
        else $error("load counts not cleared during computation");
    mac_indices_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |->
        ({1'b0, k_reg} < inner && {1'b0, j_reg} < cols && {1'b0, i_reg} < rows))
        else $error("matrix index out of range");
    counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        a_cnt_reg <= CNT_W'(CELLS) && b_cnt_reg <= CNT_W'(CELLS))
        else $error("load count past store depth");
    drain_before_output: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_OUT_RD) && $past(state_reg == ST_DRAIN)
        |-> $past(drain_reg == 2'd0))
        else $error("results read before pipeline drained");

endmodule

/* sv/matrix_multiply_power_core.sv */
// matrix multiply and matrix power core, signed Q16.16 elements
// load: one element per cycle while idle; the computation starts in the cycle after the final element
// compute: each product pass feeds every term through the single shared multiply-accumulate
//   pipeline, which then drains; power mode runs exponent-1 passes, none for 0 or 1
// output: each element goes through the registered store read before the output register
// reset clears control state and sets registers to mode 0, dimensions 8, exponent 1;
//   the element stores are not cleared
`timescale 1ns / 1ps
module matrix_multiply_power_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mmp_pkg::in_item_t              in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mmp_pkg::out_item_t             out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mmp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mmp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencing and configuration
    mmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_item.cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    // stores and arithmetic
    mmp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .element   (in_item.element),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
